@@ hw/rtl/knsi_pkg.sv @@
// ----------------------------------------------------------------------------
// knsi_pkg: shared types and constants of the nearest-neighbour list
// Field widths, operation codes, register indexes and the structs that pass
// between the list cells, the output buffer and the top level.
// ----------------------------------------------------------------------------
package knsi_pkg;

    localparam int DIST_W  = 32;
    localparam int ID_W    = 16;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int RIDX_W  = 4;
    localparam int RAD_W   = 16;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    // Operation codes carried in the low bits of the input beat.
    typedef enum logic [1:0] {
        OP_OFFER = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } knsi_op_t;

    // Register index, taken from paddr[2].
    localparam logic REG_SIGHT_RADIUS = 1'b0;
    localparam logic REG_MAX_COUNT    = 1'b1;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic              commit;
        logic [DIST_W-1:0] dist_sq;
        logic [ID_W-1:0]   id;
    } knsi_cmd_t;

    // What one cell hands to its right-hand neighbour.
    typedef struct packed {
        logic              lt;
        logic [DIST_W-1:0] dist_sq;
        logic [ID_W-1:0]   id;
    } knsi_link_t;

    // One result item.
    typedef struct packed {
        logic               accepted;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic               read_valid;
        logic [DIST_W-1:0]  read_dist;
        logic [ID_W-1:0]    read_id;
    } knsi_result_t;

endpackage

@@ hw/rtl/knsi_cell.sv @@
// ----------------------------------------------------------------------------
// knsi_cell: one position of the sorted neighbour list
// Holds one distance and id, compares them with the candidate, and on an
// insertion either keeps its entry, takes the candidate or takes the entry of
// its left-hand neighbour.
// ----------------------------------------------------------------------------
module knsi_cell (
    input  logic                clk,
    input  knsi_pkg::knsi_cmd_t cmd,
    input  logic                occupied,
    input  logic                in_limit,
    input  knsi_pkg::knsi_link_t prev,
    output knsi_pkg::knsi_link_t link,
    output logic                is_pos
);
    import knsi_pkg::*;

    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic              lt;

    // The candidate goes behind this entry only if it is held, inside the
    // limit and strictly nearer.
    assign lt     = occupied & in_limit & (dist_reg < cmd.dist_sq);
    assign is_pos = in_limit & ~lt & prev.lt;

    assign link.lt      = lt;
    assign link.dist_sq = dist_reg;
    assign link.id      = id_reg;

    always_comb
    begin
        dist_next = dist_reg;
        id_next   = id_reg;
        if (cmd.commit)
        begin
            if (is_pos)
            begin
                dist_next = cmd.dist_sq;
                id_next   = cmd.id;
            end
            else if (!prev.lt)
            begin
                dist_next = prev.dist_sq;
                id_next   = prev.id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        id_reg   <= id_next;
    end

endmodule

@@ hw/rtl/knsi_out_buf.sv @@
// ----------------------------------------------------------------------------
// knsi_out_buf: two-place output buffer for result beats
// An output register with a skid register behind it, so that a new result
// can be taken while the previous one waits on the downstream side.
// ----------------------------------------------------------------------------
module knsi_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  knsi_pkg::knsi_result_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output knsi_pkg::knsi_result_t out_data
);
    import knsi_pkg::*;

    logic         main_valid_reg;
    logic         main_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    knsi_result_t main_reg;
    knsi_result_t main_next;
    knsi_result_t skid_reg;
    knsi_result_t skid_next;
    logic         in_fire;

    assign in_ready  = ~skid_valid_reg;
    assign in_fire   = in_valid & ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ hw/rtl/k_nearest_sorted_insert.sv @@
// ----------------------------------------------------------------------------
// k_nearest_sorted_insert: sorted list of the nearest neighbours
// A row of list cells kept in order of squared distance, with offer, clear
// and read operations, an APB register port and a buffered result stream.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the output buffer has room and
// returns exactly one result beat for each. The list is a row of MAX_NEIGHBOURS
// cells: every cell compares its own distance with the offered one in the same
// cycle, so an offer, a clear or a read take one compare-and-shift across
// the row, and that compare-and-shift is what sets the rate. A two-place output
// buffer lets a new beat in while a result is still waiting downstream; the
// input stalls only when both places are full. Offers at or beyond the square
// of sight_radius are dropped, as are offers whose sorted position is not below
// min(max_count, MAX_NEIGHBOURS). After reset the list is empty at once: no
// clearing pass is needed, and cells beyond the entry count are never shown.
// The user must write registers only while the block is idle; the block does
// not enforce it. sight_radius is at byte address 0, max_count at address 4.
// ----------------------------------------------------------------------------
module k_nearest_sorted_insert #(
    parameter int MAX_NEIGHBOURS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0: operation[1:0], dist_sq[33:2], neighbour_id[49:34],
    // read_index[53:50], zero padding[55:54].
    input  logic [55:0] s_axis_tdata,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // From bit 0: accepted[0], slot[4:1], count[9:5], read_valid[10],
    // read_dist[42:11], read_id[58:43], zero padding[63:59].
    output logic [63:0] m_axis_tdata
);
    import knsi_pkg::*;

    // Width of the entry count and of the limit, which both reach
    // MAX_NEIGHBOURS.
    localparam int CW = $clog2(MAX_NEIGHBOURS + 1);
    // Cells reachable through the four-bit read index.
    localparam int NRD = (MAX_NEIGHBOURS < 16) ? MAX_NEIGHBOURS : 16;
    localparam int LIMIT_RST = (MAX_NEIGHBOURS < 16) ? MAX_NEIGHBOURS : 16;
    localparam logic [DIST_W-1:0] CUTOFF_RST = 32'hFFFE_0001;

    // Configuration state. The squared cutoff and the effective limit are
    // worked out when the register is written, so the item path sees them
    // ready-made.
    logic [RAD_W-1:0]   sight_radius_reg;
    logic [COUNT_W-1:0] max_count_reg;
    logic [DIST_W-1:0]  cutoff_reg;
    logic [CW-1:0]      limit_reg;
    logic               cfg_write;

    // List state.
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW:0]        count_inc;

    // Item decode.
    logic               in_fire;
    knsi_op_t           op;
    logic [DIST_W-1:0]  cand_dist;
    logic [ID_W-1:0]    cand_id;
    logic [RIDX_W-1:0]  read_index;
    logic               in_range;
    logic               commit;

    knsi_cmd_t          cmd;
    knsi_link_t         link [MAX_NEIGHBOURS];
    logic [MAX_NEIGHBOURS-1:0] is_pos;
    logic [MAX_NEIGHBOURS-1:0] occupied;
    logic [MAX_NEIGHBOURS-1:0] in_limit;

    logic [SLOT_W-1:0]  slot_or;
    logic               rd_hit;
    logic [DIST_W-1:0]  rd_dist;
    logic [ID_W-1:0]    rd_id;

    knsi_result_t       result;
    knsi_result_t       out_result;
    logic               buf_ready;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sight_radius_reg <= RAD_W'(16'hFFFF);
            max_count_reg    <= COUNT_W'(16);
            cutoff_reg       <= CUTOFF_RST;
            limit_reg        <= CW'(LIMIT_RST);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SIGHT_RADIUS:
                begin
                    sight_radius_reg <= pwdata[RAD_W-1:0];
                    cutoff_reg       <= DIST_W'(pwdata[RAD_W-1:0])
                                      * DIST_W'(pwdata[RAD_W-1:0]);
                end
                REG_MAX_COUNT:
                begin
                    max_count_reg <= pwdata[COUNT_W-1:0];
                    limit_reg     <= (32'(pwdata[COUNT_W-1:0]) < 32'(MAX_NEIGHBOURS))
                                   ? CW'(pwdata[COUNT_W-1:0]) : CW'(MAX_NEIGHBOURS);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SIGHT_RADIUS: prdata = 32'(sight_radius_reg);
            REG_MAX_COUNT:    prdata = 32'(max_count_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    assign s_axis_tready = buf_ready;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign op            = knsi_op_t'(s_axis_tdata[1:0]);
    assign cand_dist     = s_axis_tdata[33:2];
    assign cand_id       = s_axis_tdata[49:34];
    assign read_index    = s_axis_tdata[53:50];
    assign in_range      = cand_dist < cutoff_reg;

    // An offer goes in only when some cell inside the limit claims the
    // sorted position; otherwise the list is left untouched.
    assign commit      = in_fire & (op == OP_OFFER) & in_range & (|is_pos);
    assign cmd.commit  = commit;
    assign cmd.dist_sq = cand_dist;
    assign cmd.id      = cand_id;

    // ------------------------------------------------------------------
    // Row of list cells. Cell 0 has no left-hand neighbour, so it sees a
    // neighbour that is always nearer and never shifts in.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_NEIGHBOURS; g++)
    begin : g_cell
        knsi_link_t prev;

        assign occupied[g] = CW'(g) < count_reg;
        assign in_limit[g] = CW'(g) < limit_reg;

        if (g == 0)
        begin : g_first
            assign prev.lt      = 1'b1;
            assign prev.dist_sq = '0;
            assign prev.id      = '0;
        end
        else
        begin : g_rest
            assign prev = link[g-1];
        end

        knsi_cell u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .occupied (occupied[g]),
            .in_limit (in_limit[g]),
            .prev     (prev),
            .link     (link[g]),
            .is_pos   (is_pos[g])
        );
    end

    // Insertion position: at most one cell claims it.
    always_comb
    begin
        slot_or = '0;
        for (int i = 0; i < MAX_NEIGHBOURS; i++)
        begin
            if (is_pos[i])
            begin
                slot_or = slot_or | SLOT_W'(i);
            end
        end
    end

    // Read of one list position. Only positions below the entry count hit.
    always_comb
    begin
        rd_hit  = 1'b0;
        rd_dist = '0;
        rd_id   = '0;
        for (int i = 0; i < NRD; i++)
        begin
            if ((RIDX_W'(i) == read_index) && occupied[i])
            begin
                rd_hit  = 1'b1;
                rd_dist = rd_dist | link[i].dist_sq;
                rd_id   = rd_id | link[i].id;
            end
        end
    end

    // ------------------------------------------------------------------
    // Entry count. An insertion adds one entry but never leaves more than
    // the limit, so a limit lowered earlier takes effect here.
    // ------------------------------------------------------------------
    assign count_inc = {1'b0, count_reg} + (CW + 1)'(1);

    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            unique case (op)
                OP_OFFER:
                begin
                    if (commit)
                    begin
                        count_next = (count_inc > {1'b0, limit_reg})
                                   ? limit_reg : count_inc[CW-1:0];
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    always_comb
    begin
        result.accepted   = commit;
        result.slot       = commit ? slot_or : '0;
        result.count      = COUNT_W'(count_next);
        result.read_valid = (op == OP_READ) & rd_hit;
        result.read_dist  = ((op == OP_READ) & rd_hit) ? rd_dist : '0;
        result.read_id    = ((op == OP_READ) & rd_hit) ? rd_id : '0;
    end

    knsi_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (buf_ready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {5'b0,
                           out_result.read_id,
                           out_result.read_dist,
                           out_result.read_valid,
                           out_result.count,
                           out_result.slot,
                           out_result.accepted};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_NEIGHBOURS)
        else $error("entry count beyond the number of cells");

    a_single_pos : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op == OP_OFFER) |-> $onehot0(is_pos))
        else $error("more than one cell claims the insertion position");

    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op == OP_CLEAR) |=> (count_reg == '0))
        else $error("list not empty after a clear");

    a_insert_holds : assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (count_reg != '0))
        else $error("list empty after an insertion");

endmodule
